// ===== hdl/pil_pkg.sv =====
// Package with sizes, mode codes and status codes of the pooled indexed list.
package pil_pkg;

  localparam int CAPACITY  = 16;
  localparam int WORD_BITS = 32;
  localparam int SLOT_W    = $clog2(CAPACITY);
  localparam int LEN_W     = $clog2(CAPACITY + 1);

  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_READ   = 3'd1;
  localparam logic [2:0] MODE_DELETE = 3'd2;
  localparam logic [2:0] MODE_PEEK   = 3'd3;
  localparam logic [2:0] MODE_RESET  = 3'd4;
  localparam logic [2:0] MODE_DROP   = 3'd5;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_BADPOS = 2'd1;
  localparam logic [1:0] STAT_FULL   = 2'd2;
  localparam logic [1:0] STAT_EMPTY  = 2'd3;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [LEN_W-1:0]  len_t;

endpackage

// ===== hdl/pooled_indexed_list.sv =====
// Top level of the pooled indexed list: linked nodes in a fixed slot pool.
//
// An item (mode, position, item_word) is taken at a rising edge where start
// is high and busy is low. Every item gives exactly one result: status,
// read_word and count are valid during the single cycle in which done is
// high. The receiver cannot stall; it must take the result in that cycle.
// Node words and links sit in two synchronous-read memories; positional
// operations walk the links one slot per cycle.
// Steps from the accepting edge to the result cycle:
//   errors, cursor reset and unused modes: answered from the idle state,
//   peek: a read of the word and link at the cursor,
//   insert: walk to position, write node, link predecessor unless at zero,
//   read and delete: walk to position, then read or unlink the node,
//   drop peeked items: walk over the peeked items, freeing each slot.
// busy is high from acceptance until the result cycle; a new item may be
// started in the result cycle itself.
// A synchronous reset empties the list at once; the memories are not
// cleared, since no entry is read before it is written.
module pooled_indexed_list
  import pil_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  mode,
  input  logic [4:0]  position,
  input  logic [31:0] item_word,
  output logic        busy,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] read_word,
  output logic [4:0]  count
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WSTART = 3'd1;
  localparam logic [2:0] ST_WALK   = 3'd2;
  localparam logic [2:0] ST_OPER   = 3'd3;
  localparam logic [2:0] ST_INS2   = 3'd4;
  localparam logic [2:0] ST_DEL2   = 3'd5;
  localparam logic [2:0] ST_RDW    = 3'd6;
  localparam logic [2:0] ST_PEEK2  = 3'd7;

  logic [WORD_BITS-1:0] words [CAPACITY];
  slot_t                links [CAPACITY];

  logic [2:0]           state;
  logic [CAPACITY-1:0]  slot_busy;
  slot_t                head;
  slot_t                cursor;
  len_t                 peeked;
  len_t                 length;

  logic [2:0]           mode_q;
  logic [4:0]           pos_q;
  logic [WORD_BITS-1:0] word_q;
  slot_t                cur;
  slot_t                prev;
  slot_t                free_slot;
  len_t                 rem;
  len_t                 drop_n;

  logic [WORD_BITS-1:0] word_rd;
  slot_t                link_rd;
  slot_t                word_addr;
  slot_t                link_addr;
  logic                 word_we;
  logic                 link_we;
  slot_t                link_waddr;
  slot_t                link_wdata;

  slot_t                free_idx;
  logic                 pool_full;
  len_t                 pos_len;

  assign busy    = (state != ST_IDLE);
  assign count   = 5'(length);
  assign pos_len = LEN_W'(position);

  always_comb begin
    free_idx  = '0;
    pool_full = &slot_busy;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!slot_busy[i]) free_idx = SLOT_W'(i);
    end
  end

  always_comb begin
    link_addr   = cursor;
    word_addr   = cursor;
    word_we     = 1'b0;
    link_we     = 1'b0;
    link_waddr  = free_slot;
    link_wdata  = '0;
    case (state)
      ST_WSTART: link_addr = cur;
      ST_WALK: link_addr = link_rd;
      ST_OPER: begin
        link_addr = cur;
        word_addr = cur;
        if (mode_q == MODE_INSERT) begin
          word_we    = 1'b1;
          link_we    = 1'b1;
          link_waddr = free_slot;
          link_wdata = (LEN_W'(pos_q) == length) ? slot_t'(0) : cur;
        end
      end
      ST_INS2: begin
        link_we    = 1'b1;
        link_waddr = prev;
        link_wdata = free_slot;
      end
      ST_DEL2: begin
        link_we    = (pos_q != 5'd0);
        link_waddr = prev;
        link_wdata = link_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (word_we) words[free_slot] <= word_q;
    word_rd <= words[word_addr];
  end

  always_ff @(posedge clk) begin
    if (link_we) links[link_waddr] <= link_wdata;
    link_rd <= links[link_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      slot_busy <= '0;
      head      <= '0;
      cursor    <= '0;
      peeked    <= '0;
      length    <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            mode_q    <= mode;
            pos_q     <= position;
            word_q    <= item_word[WORD_BITS-1:0];
            cur       <= head;
            free_slot <= free_idx;
            rem       <= pos_len;
            status    <= STAT_OK;
            read_word <= '0;
            case (mode)
              MODE_INSERT: begin
                if (pos_len > length || position > 5'(CAPACITY)) begin
                  status <= STAT_BADPOS;
                  done   <= 1'b1;
                end else if (pool_full) begin
                  status <= STAT_FULL;
                  done   <= 1'b1;
                end else begin
                  state <= ST_WSTART;
                end
              end
              MODE_READ, MODE_DELETE: begin
                if (pos_len >= length || position >= 5'(CAPACITY)) begin
                  status <= STAT_BADPOS;
                  done   <= 1'b1;
                end else begin
                  state <= ST_WSTART;
                end
              end
              MODE_PEEK: begin
                if (peeked >= length) begin
                  status <= STAT_EMPTY;
                  done   <= 1'b1;
                end else begin
                  state <= ST_PEEK2;
                end
              end
              MODE_RESET: begin
                cursor <= head;
                peeked <= '0;
                done   <= 1'b1;
              end
              MODE_DROP: begin
                rem    <= (peeked < length) ? peeked : length;
                drop_n <= (peeked < length) ? peeked : length;
                state  <= ST_WSTART;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        ST_WSTART: begin
          state <= (rem == '0) ? ST_OPER : ST_WALK;
        end
        ST_WALK: begin
          prev <= cur;
          cur  <= link_rd;
          rem  <= rem - len_t'(1);
          if (mode_q == MODE_DROP) slot_busy[cur] <= 1'b0;
          if (rem == len_t'(1)) state <= ST_OPER;
        end
        ST_OPER: begin
          case (mode_q)
            MODE_INSERT: begin
              slot_busy[free_slot] <= 1'b1;
              length <= length + len_t'(1);
              peeked <= '0;
              if (pos_q == 5'd0) begin
                head   <= free_slot;
                cursor <= free_slot;
                done   <= 1'b1;
                state  <= ST_IDLE;
              end else begin
                state <= ST_INS2;
              end
            end
            MODE_READ: state <= ST_RDW;
            MODE_DELETE: state <= ST_DEL2;
            MODE_DROP: begin
              length <= length - drop_n;
              head   <= cursor;
              peeked <= '0;
              done   <= 1'b1;
              state  <= ST_IDLE;
            end
            default: begin
              done  <= 1'b1;
              state <= ST_IDLE;
            end
          endcase
        end
        ST_INS2: begin
          cursor <= head;
          done   <= 1'b1;
          state  <= ST_IDLE;
        end
        ST_DEL2: begin
          slot_busy[cur] <= 1'b0;
          length <= length - len_t'(1);
          peeked <= '0;
          if (pos_q == 5'd0) begin
            head   <= link_rd;
            cursor <= link_rd;
          end else begin
            cursor <= head;
          end
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        ST_RDW: begin
          read_word <= 32'(word_rd);
          done      <= 1'b1;
          state     <= ST_IDLE;
        end
        ST_PEEK2: begin
          read_word <= 32'(word_rd);
          cursor    <= link_rd;
          peeked    <= peeked + len_t'(1);
          done      <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/pil_checker.sv =====
// Port-level checker for the pooled indexed list, bound to the top level.
module pil_checker
  import pil_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [31:0] read_word,
  input logic [4:0]  count
);

  // A result is only shown once the block has finished its item.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // An accepted item either starts work or answers in the next cycle.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted item was dropped");

  // The list never holds more entries than the pool has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (count <= 5'(CAPACITY)))
    else $error("count above capacity");

  // A failed operation returns no data word.
  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_OK) |-> (read_word == 32'd0))
    else $error("data word returned with an error status");

endmodule

bind pooled_indexed_list pil_checker u_pil_checker (.*);

// ===== tb/list_op_checker.sv =====
// Checker for the pooled indexed list: predicts each item's result and compares it.
`timescale 1ns / 1ps

module list_op_checker
  import pil_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  mode,
  input  logic [4:0]  position,
  input  logic [31:0] item_word,
  input  logic        done,
  input  logic [1:0]  status,
  input  logic [31:0] read_word,
  input  logic [4:0]  count,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] word;
    logic [4:0]  length;
  } op_outcome_t;

  op_outcome_t outcomes_due[$];

  logic [WORD_BITS-1:0] node_word [CAPACITY];
  slot_t                node_link [CAPACITY];
  logic                 slot_used [CAPACITY];
  slot_t                head_at;
  slot_t                cursor_at;
  len_t                 peeked;
  len_t                 list_len;

  int fails = 0;
  int n_checked = 0;

  function automatic slot_t slot_of(input int unsigned pos);
    slot_t s;
    s = head_at;
    for (int unsigned i = 0; i < pos; i++) s = node_link[s];
    return s;
  endfunction

  task automatic apply_list_op(input logic [2:0] m, input logic [4:0] p,
                               input logic [31:0] w, output op_outcome_t o);
    slot_t       free_s;
    slot_t       prev;
    slot_t       victim;
    slot_t       s;
    logic        found;
    int unsigned n;
    o = '0;
    o.status = STAT_OK;
    case (m)
      MODE_INSERT: begin
        if (p > list_len) begin
          o.status = STAT_BADPOS;
        end else begin
          found = 1'b0;
          free_s = '0;
          for (int i = 0; i < CAPACITY; i++) begin
            if (!found && !slot_used[i]) begin
              free_s = slot_t'(i);
              found = 1'b1;
            end
          end
          if (!found) begin
            o.status = STAT_FULL;
          end else begin
            slot_used[free_s] = 1'b1;
            node_word[free_s] = w;
            if (p == 0) begin
              node_link[free_s] = (list_len == 0) ? slot_t'(0) : head_at;
              head_at = free_s;
            end else begin
              prev = slot_of(p - 1);
              node_link[free_s] = (p == list_len) ? slot_t'(0) : node_link[prev];
              node_link[prev] = free_s;
            end
            cursor_at = head_at;
            peeked = '0;
            list_len = list_len + 1'b1;
          end
        end
      end
      MODE_READ: begin
        if (p >= list_len) o.status = STAT_BADPOS;
        else o.word = node_word[slot_of(p)];
      end
      MODE_DELETE: begin
        if (p >= list_len) begin
          o.status = STAT_BADPOS;
        end else begin
          victim = slot_of(p);
          if (p == 0) begin
            head_at = node_link[victim];
          end else begin
            prev = slot_of(p - 1);
            node_link[prev] = node_link[victim];
          end
          slot_used[victim] = 1'b0;
          cursor_at = head_at;
          peeked = '0;
          list_len = list_len - 1'b1;
        end
      end
      MODE_PEEK: begin
        if (peeked >= list_len) begin
          o.status = STAT_EMPTY;
        end else begin
          s = cursor_at;
          o.word = node_word[s];
          cursor_at = node_link[s];
          peeked = peeked + 1'b1;
        end
      end
      MODE_RESET: begin
        cursor_at = head_at;
        peeked = '0;
      end
      MODE_DROP: begin
        s = head_at;
        n = 0;
        while (n < peeked && n < list_len) begin
          slot_used[s] = 1'b0;
          s = node_link[s];
          n++;
        end
        list_len = list_len - len_t'(n);
        head_at = cursor_at;
        peeked = '0;
      end
      default: begin
      end
    endcase
    o.length = list_len;
  endtask

  always @(posedge clk) begin
    op_outcome_t want;
    op_outcome_t next;
    if (rst) begin
      for (int i = 0; i < CAPACITY; i++) begin
        node_link[i] = '0;
        slot_used[i] = 1'b0;
      end
      head_at = '0;
      cursor_at = '0;
      peeked = '0;
      list_len = '0;
      outcomes_due.delete();
    end else begin
      if (done) begin
        if (outcomes_due.size() == 0) begin
          $error("result with no item outstanding: status %0d read_word %h count %0d",
                 status, read_word, count);
          fails++;
        end else begin
          want = outcomes_due.pop_front();
          n_checked++;
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fails++;
          end
          if (read_word !== want.word) begin
            $error("read_word: expected %h, got %h", want.word, read_word);
            fails++;
          end
          if (count !== want.length) begin
            $error("count: expected %0d, got %0d", want.length, count);
            fails++;
          end
        end
      end
      if (start && !busy) begin
        apply_list_op(mode, position, item_word, next);
        outcomes_due.push_back(next);
      end
    end
    fail_count <= fails;
    pending <= outcomes_due.size();
    checked <= n_checked;
  end

endmodule

// ===== tb/tb_pooled_indexed_list.sv =====
// Testbench top for the pooled indexed list: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_pooled_indexed_list;
  import pil_pkg::*;

  localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
  localparam int         RANDOM_ITEMS   = 1500;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  mode = MODE_INSERT;
  logic [4:0]  position = '0;
  logic [31:0] item_word = '0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [31:0] read_word;
  logic [4:0]  count;

  int fail_count;
  int pending_results;
  int results_checked;

  int items_sent = 0;
  int len_seen = 0;
  int n_ok = 0;
  int n_badpos = 0;
  int n_full = 0;
  int n_empty = 0;

  pooled_indexed_list dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .mode      (mode),
    .position  (position),
    .item_word (item_word),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .read_word (read_word),
    .count     (count)
  );

  list_op_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .position   (position),
    .item_word  (item_word),
    .done       (done),
    .status     (status),
    .read_word  (read_word),
    .count      (count),
    .fail_count (fail_count),
    .pending    (pending_results),
    .checked    (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      len_seen <= int'(count);
      case (status)
        STAT_OK:     n_ok++;
        STAT_BADPOS: n_badpos++;
        STAT_FULL:   n_full++;
        default:     n_empty++;
      endcase
    end
  end

  task automatic send_item(input logic [2:0] m, input logic [4:0] p,
                           input logic [31:0] w, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= m;
    position <= p;
    item_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [4:0] pick_position(input logic [2:0] m, input int len);
    int hi;
    hi = (m == MODE_INSERT) ? len : len - 1;
    if (hi < 0 || $urandom_range(0, 9) == 0) return 5'($urandom_range(0, 16));
    return 5'($urandom_range(0, hi));
  endfunction

  // Phase 0 fills the pool, phase 1 mixes, phase 2 empties it again.
  function automatic logic [2:0] pick_mode(input int phase);
    int r;
    int w_ins;
    int w_rd;
    int w_del;
    int w_pk;
    int w_rs;
    r = $urandom_range(0, 99);
    if (r == 0) return $urandom_range(0, 1) ? MODE_UNUSED_HI : MODE_UNUSED_LO;
    case (phase)
      0: begin w_ins = 60; w_rd = 15; w_del = 5;  w_pk = 10; w_rs = 4; end
      1: begin w_ins = 30; w_rd = 20; w_del = 20; w_pk = 15; w_rs = 6; end
      default: begin w_ins = 14; w_rd = 15; w_del = 35; w_pk = 20; w_rs = 5; end
    endcase
    r = r - 1;
    if (r < w_ins) return MODE_INSERT;
    r = r - w_ins;
    if (r < w_rd) return MODE_READ;
    r = r - w_rd;
    if (r < w_del) return MODE_DELETE;
    r = r - w_del;
    if (r < w_pk) return MODE_PEEK;
    r = r - w_pk;
    if (r < w_rs) return MODE_RESET;
    return MODE_DROP;
  endfunction

  initial begin
    int          n_random;
    int          n_directed;
    int          gap;
    int          n_peeks;
    logic [2:0]  m;
    logic [4:0]  p;
    n_random = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-list errors, unused modes, head, middle and tail inserts,
    // reads and deletes at the ends, peek past the end and dropping peeked items.
    send_item(MODE_PEEK,      5'd0,  32'h0,         $urandom_range(0, 18));
    send_item(MODE_READ,      5'd0,  32'h0,         $urandom_range(0, 18));
    send_item(MODE_DELETE,    5'd0,  32'h0,         $urandom_range(0, 18));
    send_item(MODE_INSERT,    5'd1,  32'hDEAD_BEEF, $urandom_range(0, 18));
    send_item(MODE_DROP,      5'd0,  32'h0,         0);
    send_item(MODE_RESET,     5'd0,  32'h0,         0);
    send_item(MODE_UNUSED_LO, 5'd31, 32'hFFFF_FFFF, $urandom_range(0, 18));
    send_item(MODE_UNUSED_HI, 5'd16, 32'h0,         0);
    send_item(MODE_INSERT,    5'd0,  32'h0000_0000, 0);
    send_item(MODE_INSERT,    5'd1,  32'hFFFF_FFFF, $urandom_range(0, 18));
    send_item(MODE_INSERT,    5'd1,  32'hA5A5_A5A5, 0);
    send_item(MODE_INSERT,    5'd0,  32'h1234_5678, 0);
    send_item(MODE_INSERT,    5'd16, 32'h5A5A_5A5A, $urandom_range(0, 18));
    send_item(MODE_READ,      5'd3,  32'h0,         0);
    send_item(MODE_READ,      5'd4,  32'h0,         $urandom_range(0, 18));
    send_item(MODE_PEEK,      5'd0,  32'h0,         0);
    send_item(MODE_PEEK,      5'd15, 32'h0,         0);
    send_item(MODE_DROP,      5'd0,  32'h0,         0);
    send_item(MODE_PEEK,      5'd0,  32'h0,         $urandom_range(0, 18));
    send_item(MODE_RESET,     5'd0,  32'h0,         0);
    send_item(MODE_DELETE,    5'd1,  32'h0,         0);
    send_item(MODE_DELETE,    5'd0,  32'h0,         $urandom_range(0, 18));
    send_item(MODE_INSERT,    5'd0,  pick_word(),   0);
    send_item(MODE_PEEK,      5'd0,  32'h0,         0);
    send_item(MODE_PEEK,      5'd0,  32'h0,         0);
    n_directed = items_sent;
    wait_drained();

    while (n_random < RANDOM_ITEMS) begin
      m = pick_mode((n_random / 100) % 3);
      // A drop usually follows a short run of peeks, as in normal use.
      if (m == MODE_DROP && $urandom_range(0, 4) != 0) begin
        n_peeks = $urandom_range(1, 6);
        repeat (n_peeks) begin
          gap = ((n_random / 40) % 4 == 0) ? 0 : $urandom_range(0, 18);
          send_item(MODE_PEEK, 5'($urandom_range(0, 31)), pick_word(), gap);
          n_random++;
        end
      end
      gap = ((n_random / 40) % 4 == 0) ? 0 : $urandom_range(0, 18);
      p = pick_position(m, len_seen);
      send_item(m, p, pick_word(), gap);
      if (m != MODE_UNUSED_LO && m != MODE_UNUSED_HI) n_random++;
      if (n_random % 500 == 0) wait_drained();
    end

    wait_drained();
    repeat (CAPACITY + 8) @(posedge clk);

    $display("Sent %0d items (%0d directed, rest random); checked %0d results.",
             items_sent, n_directed, results_checked);
    $display("Results: %0d ok, %0d bad position, %0d pool full, %0d nothing to peek.",
             n_ok, n_badpos, n_full, n_empty);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
